[rtl/pcgbr_pkg.sv]
// ----------------------------------------------------------------------------
// pcgbr_pkg
// shared types and constants of the bounded pcg32 generator
// ----------------------------------------------------------------------------
package pcgbr_pkg;

    localparam logic [63:0] PCG_MULT = 64'd6364136223846793005;
    localparam int unsigned CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SEED = 1'b0,
        CFG_INCR = 1'b1
    } t_cfg_idx;

    // request as stored in the queue between front and back
    typedef struct packed {
        logic        ranged;   // ranged draw with nonzero range
        logic        zero;     // ranged draw with range zero
        logic [31:0] range;
    } t_req;

    // xsh-rr output permutation of one state word
    function automatic logic [31:0] pcg_output(input logic [63:0] s);
        logic [31:0] xs;
        logic [4:0]  rot;
        logic [63:0] dbl;
        begin
            xs  = 32'(((s >> 18) ^ s) >> 27);
            rot = s[63:59];
            dbl = {xs, xs} >> rot;
            pcg_output = dbl[31:0];
        end
    endfunction

endpackage

[rtl/pcg32_bounded_random.sv]
// ----------------------------------------------------------------------------
// pcg32_bounded_random
// pcg32 xsh-rr generator with lemire bounded draws
// ----------------------------------------------------------------------------
// A request is either a raw draw (kind 0) or a draw below i_range (kind 1,
// range 0 gives 0). A raw draw leaves the queue and then takes one generator
// step that loads the output register; a ranged draw accepted on its first
// test passes the step, multiply, test and finish states, and each rejected
// draw goes back through step, multiply and test. The first rejection test
// that needs the threshold first runs a bit-serial remainder unit and then a
// second test. The 64-bit state update uses 32x32 partial products in one
// step. Results wait in an output register and the back end takes no new
// request until it is accepted; the front queue of two requests keeps
// accepting meanwhile. Writing the seed (index 0) reloads the state; the
// increment (index 1) is forced odd. Configuration writes are held off
// while a request is queued or a draw is under way.
module pcg32_bounded_random import pcgbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [31:0] i_range,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value
);

    logic q_valid, q_pop;
    logic back_idle;
    t_req q_req;

    // config writes only with nothing queued and no draw running
    assign o_cfg_ready = back_idle && !q_valid;

    pcgbr_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind, .i_range,
        .o_q_valid(q_valid), .o_q_req(q_req), .i_q_pop(q_pop)
    );

    pcgbr_back u_back (
        .i_clk, .i_rst_n, .i_cfg_valid(i_cfg_valid && o_cfg_ready),
        .i_cfg_index, .i_cfg_data,
        .i_q_valid(q_valid), .i_q_req(q_req), .o_q_pop(q_pop),
        .o_idle(back_idle), .o_valid, .i_ready, .o_value
    );

endmodule

[rtl/pcgbr_front.sv]
// ----------------------------------------------------------------------------
// pcgbr_front
// accepts requests, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
module pcgbr_front import pcgbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [31:0] i_range,
    output logic        o_q_valid,
    output t_req        o_q_req,
    input  logic        i_q_pop
);

    // two-entry queue
    t_req       r_mem [2];
    logic       r_wp, n_wp;
    logic       r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_req       req;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_req   = r_mem[r_rp];

    always_comb begin
        req.ranged = i_kind && (i_range != 32'd0);
        req.zero   = i_kind && (i_range == 32'd0);
        req.range  = i_range;
        n_wp  = r_wp ^ push;
        n_rp  = r_rp ^ i_q_pop;
        n_cnt = r_cnt + 2'(push) - 2'(i_q_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (push) r_mem[r_wp] <= req;
    end

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_q_pop |-> o_q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");
    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !i_q_pop |=> r_cnt == $past(r_cnt) + 2'd1)
        else $error("queue count not updated on push");

endmodule

[rtl/pcgbr_back.sv]
// ----------------------------------------------------------------------------
// pcgbr_back
// generator state, multiply-and-reject loop, threshold remainder, output reg
// ----------------------------------------------------------------------------
module pcgbr_back import pcgbr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_q_valid,
    input  t_req        i_q_req,
    output logic        o_q_pop,
    output logic        o_idle,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_value
);

    typedef enum logic [2:0] {
        S_IDLE, S_STEP, S_MUL, S_CHECK, S_DIV, S_FIN
    } t_state;

    t_state      r_state;
    logic [63:0] r_gen, r_incr;
    logic [31:0] r_x;       // drawn output
    logic [63:0] r_prod;
    t_req        r_req;
    logic        r_thr_ok;  // threshold known
    logic [31:0] r_thr;     // remainder being built / final threshold
    logic [31:0] r_dvd;     // dividend bits still to shift in
    logic [5:0]  r_cnt;
    logic        r_oval;
    logic [31:0] r_oval_d;

    // mult split into 32x32 partial products, only low half of the cross terms
    logic [63:0] p_lo;
    logic [31:0] p_hi;
    logic [31:0] n_thr_sh;
    logic [32:0] rem_sh;

    assign p_lo = 64'(r_gen[31:0]) * 64'(PCG_MULT[31:0]);
    assign p_hi = r_gen[31:0] * PCG_MULT[63:32]
                + r_gen[63:32] * PCG_MULT[31:0];
    assign rem_sh = {r_thr, r_dvd[31]};
    assign n_thr_sh = (rem_sh >= {1'b0, r_req.range}) ?
                      32'(rem_sh - {1'b0, r_req.range}) : rem_sh[31:0];

    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid && !r_oval;
    assign o_idle   = (r_state == S_IDLE);
    assign o_valid  = r_oval;
    assign o_value  = r_oval_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_gen   <= 64'd0;
            r_incr  <= 64'd1;
            r_oval  <= 1'b0;
        end else begin
            if (r_oval && i_ready) r_oval <= 1'b0;
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_SEED: r_gen  <= i_cfg_data;
                    CFG_INCR: r_incr <= i_cfg_data | 64'd1;
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_q_pop) begin
                        r_req    <= i_q_req;
                        r_thr_ok <= 1'b0;
                        r_state  <= S_STEP;
                    end
                end
                S_STEP: begin
                    r_x   <= pcg_output(r_gen);
                    r_gen <= (p_lo + {p_hi, 32'd0}) + r_incr;
                    if (r_req.ranged) r_state <= S_MUL;
                    else begin
                        r_oval   <= 1'b1;
                        r_oval_d <= r_req.zero ? 32'd0 : pcg_output(r_gen);
                        r_state  <= S_IDLE;
                    end
                end
                S_MUL: begin
                    r_prod  <= 64'(r_x) * 64'(r_req.range);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_prod[31:0] >= r_req.range) r_state <= S_FIN;
                    else if (r_thr_ok) begin
                        r_state <= (r_prod[31:0] < r_thr) ? S_STEP : S_FIN;
                    end else begin
                        r_thr   <= 32'd0;
                        r_dvd   <= 32'd0 - r_req.range;
                        r_cnt   <= 6'd32;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    // restoring remainder, one bit per cycle
                    r_thr <= n_thr_sh;
                    r_dvd <= {r_dvd[30:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_thr_ok <= 1'b1;
                        r_state  <= S_CHECK;
                    end
                end
                S_FIN: begin
                    r_oval   <= 1'b1;
                    r_oval_d <= r_prod[63:32];
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> r_state == S_STEP) else $error("pop did not start a draw");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval && !i_ready |=> r_oval && $stable(r_oval_d))
        else $error("result dropped");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oval |-> !o_q_pop) else $error("pop while result pending");

endmodule
